### rtl/i2cmts_pkg.sv
// Shared types and codes for the I2C master transaction sequencer.
// No dependencies; imported by the sequencer top level.
`default_nettype none

package i2cmts_pkg;

   localparam int BUF_DEPTH = 16;
   localparam int BUF_AW    = $clog2(BUF_DEPTH);

   // request operations
   localparam logic [1:0] OP_LOAD   = 2'd0;
   localparam logic [1:0] OP_WRITE  = 2'd1;
   localparam logic [1:0] OP_POLL   = 2'd2;
   localparam logic [1:0] OP_STATUS = 2'd3;

   // bus commands
   localparam logic [2:0] CMD_NONE    = 3'd0;
   localparam logic [2:0] CMD_START   = 3'd1;
   localparam logic [2:0] CMD_STOP    = 3'd2;
   localparam logic [2:0] CMD_SEND    = 3'd3;
   localparam logic [2:0] CMD_RX_ACK  = 3'd4;
   localparam logic [2:0] CMD_RX_NACK = 3'd5;

   // bus status codes (status register >> 3)
   localparam logic [4:0] ST_START   = 5'd1;
   localparam logic [4:0] ST_RSTART  = 5'd2;
   localparam logic [4:0] ST_AW_ACK  = 5'd3;
   localparam logic [4:0] ST_AW_NACK = 5'd4;
   localparam logic [4:0] ST_DT_ACK  = 5'd5;
   localparam logic [4:0] ST_DT_NACK = 5'd6;
   localparam logic [4:0] ST_AR_ACK  = 5'd8;
   localparam logic [4:0] ST_AR_NACK = 5'd9;
   localparam logic [4:0] ST_DR_ACK  = 5'd10;
   localparam logic [4:0] ST_DR_NACK = 5'd11;

   // transaction end codes
   localparam logic [1:0] DONE_OK         = 2'd0;
   localparam logic [1:0] DONE_ADDR_NACK  = 2'd1;
   localparam logic [1:0] DONE_DATA_NACK  = 2'd2;
   localparam logic [1:0] DONE_UNEXPECTED = 2'd3;

   localparam logic [4:0] CNT_MAX = 5'd31;

   typedef struct packed {
      logic [2:0]        bus_command;
      logic [7:0]        tx_byte;
      logic              rx_valid;
      logic [BUF_AW-1:0] rx_index;
      logic [7:0]        rx_data;
      logic              done_res;
      logic [1:0]        done_status;
      logic              busy_res;
   } rsp_type;

endpackage

`default_nettype wire

### rtl/i2cmts_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module i2cmts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/i2c_master_transaction_sequencer_unit.sv
// A request's response passes through the stage-one and output registers after it is accepted.
// Throughput: one request per cycle; the only limit is the response stall.
// The byte buffer RAM is read in the accept cycle and its registered data joins
// the response in stage one. Reset clears the transaction control state;
// byte buffer contents are undefined until written.
// Depends on i2cmts_pkg and i2cmts_ram.
`default_nettype none

module i2c_master_transaction_sequencer_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_operation,
   input  wire logic [6:0]  req_dev_address,
   input  wire logic        req_read_not_write,
   input  wire logic [4:0]  req_xfer_length,
   input  wire logic [3:0]  req_buf_index,
   input  wire logic [7:0]  req_buf_byte,
   input  wire logic [4:0]  req_bus_status,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_bus_command,
   output logic [7:0]       rsp_tx_byte,
   output logic             rsp_rx_valid,
   output logic [3:0]       rsp_rx_index,
   output logic [7:0]       rsp_rx_data,
   output logic             rsp_done_res,
   output logic [1:0]       rsp_done_status,
   output logic             rsp_busy_res
);

   import i2cmts_pkg::*;

   // transaction control state
   logic              active_ff, active_in;
   logic              pending_ff, pending_in;
   logic [6:0]        addr_ff, addr_in;
   logic              dir_ff, dir_in;
   logic [4:0]        len_ff, len_in;
   logic [4:0]        cnt_ff, cnt_in;

   // pipeline
   logic              s1_valid_ff;
   rsp_type           s1_res_ff;
   logic              s1_use_ram_ff;
   logic [BUF_AW-1:0] s1_raddr_ff;
   logic              out_valid_ff;
   rsp_type           out_res_ff;

   logic              accept;
   logic              s1_adv;
   rsp_type           res;
   logic              use_ram;
   logic [BUF_AW-1:0] raddr;
   logic [BUF_AW-1:0] ram_raddr;
   logic              we;
   logic [BUF_AW-1:0] waddr;
   logic [7:0]        wdata;
   logic [7:0]        ram_rdata;
   logic [4:0]        cnt_inc;
   logic              store_ok;
   rsp_type           s1_final;

   assign s1_adv    = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && out_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign cnt_inc  = (cnt_ff != CNT_MAX) ? cnt_ff + 5'd1 : cnt_ff;
   assign store_ok = {1'b0, cnt_ff} < 6'(BUF_DEPTH);

   always_comb begin
      active_in  = active_ff;
      pending_in = pending_ff;
      addr_in    = addr_ff;
      dir_in     = dir_ff;
      len_in     = len_ff;
      cnt_in     = cnt_ff;
      res        = '0;
      use_ram    = 1'b0;
      raddr      = '0;
      we         = 1'b0;
      waddr      = req_buf_index[BUF_AW-1:0];
      wdata      = req_buf_byte;

      unique case (req_operation)
         OP_LOAD: begin
            if (!active_ff) begin
               addr_in    = req_dev_address;
               dir_in     = req_read_not_write;
               len_in     = ({1'b0, req_xfer_length} > 6'(BUF_DEPTH)) ?
                            5'(BUF_DEPTH) : req_xfer_length;
               pending_in = 1'b1;
            end
         end
         OP_WRITE: begin
            we = {1'b0, req_buf_index} < 5'(BUF_DEPTH);
         end
         OP_POLL: begin
            if (!active_ff && pending_ff) begin
               res.bus_command = CMD_START;
               active_in       = 1'b1;
               cnt_in          = '0;
            end
         end
         OP_STATUS: begin
            if (active_ff) begin
               unique case (req_bus_status)
                  ST_START, ST_RSTART: begin
                     res.bus_command = CMD_SEND;
                     res.tx_byte     = {addr_ff, dir_ff};
                  end
                  ST_AW_ACK: begin
                     if (len_ff == 5'd0) begin
                        res.bus_command = CMD_STOP;
                        res.done_res    = 1'b1;
                        res.done_status = DONE_OK;
                        active_in       = 1'b0;
                        pending_in      = 1'b0;
                        cnt_in          = '0;
                     end else begin
                        res.bus_command = CMD_SEND;
                        use_ram         = 1'b1;
                        raddr           = '0;
                        cnt_in          = 5'd1;
                     end
                  end
                  ST_DT_ACK: begin
                     if (cnt_ff >= len_ff) begin
                        res.bus_command = CMD_STOP;
                        res.done_res    = 1'b1;
                        res.done_status = DONE_OK;
                        active_in       = 1'b0;
                        pending_in      = 1'b0;
                        cnt_in          = '0;
                     end else begin
                        // count is below length, so the entry is in range
                        res.bus_command = CMD_SEND;
                        use_ram         = 1'b1;
                        raddr           = cnt_ff[BUF_AW-1:0];
                        cnt_in          = cnt_inc;
                     end
                  end
                  ST_AW_NACK, ST_AR_NACK: begin
                     res.bus_command = CMD_STOP;
                     res.done_res    = 1'b1;
                     res.done_status = DONE_ADDR_NACK;
                     active_in       = 1'b0;
                     pending_in      = 1'b0;
                     cnt_in          = '0;
                  end
                  ST_DT_NACK: begin
                     res.bus_command = CMD_STOP;
                     res.done_res    = 1'b1;
                     res.done_status = DONE_DATA_NACK;
                     active_in       = 1'b0;
                     pending_in      = 1'b0;
                     cnt_in          = '0;
                  end
                  ST_AR_ACK: begin
                     res.bus_command = ({1'b0, cnt_ff} + 6'd1 >= {1'b0, len_ff}) ?
                                       CMD_RX_NACK : CMD_RX_ACK;
                  end
                  ST_DR_ACK, ST_DR_NACK: begin
                     if (store_ok) begin
                        we           = 1'b1;
                        waddr        = cnt_ff[BUF_AW-1:0];
                        wdata        = req_rx_byte;
                        res.rx_valid = 1'b1;
                        res.rx_index = cnt_ff[BUF_AW-1:0];
                        res.rx_data  = req_rx_byte;
                     end
                     if (req_bus_status == ST_DR_NACK) begin
                        res.bus_command = CMD_STOP;
                        res.done_res    = 1'b1;
                        res.done_status = DONE_OK;
                        active_in       = 1'b0;
                        pending_in      = 1'b0;
                        cnt_in          = '0;
                     end else begin
                        cnt_in          = cnt_inc;
                        res.bus_command = ({1'b0, cnt_inc} + 6'd1 >= {1'b0, len_ff}) ?
                                          CMD_RX_NACK : CMD_RX_ACK;
                     end
                  end
                  default: begin
                     res.bus_command = CMD_STOP;
                     res.done_res    = 1'b1;
                     res.done_status = DONE_UNEXPECTED;
                     active_in       = 1'b0;
                     pending_in      = 1'b0;
                     cnt_in          = '0;
                  end
               endcase
            end
         end
      endcase
      res.busy_res = active_in;
   end

   // hold the read address while stage one waits so its data stays valid
   assign ram_raddr = accept ? raddr : s1_raddr_ff;

   i2cmts_ram #(
      .WIDTH (8),
      .DEPTH (BUF_DEPTH)
   ) u_buf (
      .clock   (clock),
      .wr_en   (accept && we),
      .wr_addr (waddr),
      .wr_data (wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= 1'b0;
         pending_ff <= 1'b0;
         addr_ff    <= '0;
         dir_ff     <= 1'b0;
         len_ff     <= '0;
         cnt_ff     <= '0;
      end else if (accept) begin
         active_ff  <= active_in;
         pending_ff <= pending_in;
         addr_ff    <= addr_in;
         dir_ff     <= dir_in;
         len_ff     <= len_in;
         cnt_ff     <= cnt_in;
      end
   end

   always_comb begin
      s1_final = s1_res_ff;
      if (s1_use_ram_ff) begin
         s1_final.tx_byte = ram_rdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_adv) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_res_ff     <= res;
         s1_use_ram_ff <= use_ram;
         s1_raddr_ff   <= raddr;
      end
      if (s1_adv) begin
         out_res_ff <= s1_final;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_bus_command = out_res_ff.bus_command;
   assign rsp_tx_byte     = out_res_ff.tx_byte;
   assign rsp_rx_valid    = out_res_ff.rx_valid;
   assign rsp_rx_index    = out_res_ff.rx_index;
   assign rsp_rx_data     = out_res_ff.rx_data;
   assign rsp_done_res    = out_res_ff.done_res;
   assign rsp_done_status = out_res_ff.done_status;
   assign rsp_busy_res    = out_res_ff.busy_res;

   a_stall_needs_s1 : assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> !req_stall)
      else $error("request stalled with stage one empty");

   a_idle_count_clear : assert property (@(posedge clock) disable iff (reset)
      !active_ff |-> (cnt_ff == 5'd0))
      else $error("byte count not cleared while idle");

   a_done_stops : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_done_res) |-> (rsp_bus_command == CMD_STOP && !rsp_busy_res))
      else $error("transaction end without stop or still busy");

   a_rx_cmd : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_rx_valid) |->
         (rsp_bus_command == CMD_RX_ACK || rsp_bus_command == CMD_RX_NACK ||
          rsp_bus_command == CMD_STOP))
      else $error("received byte reported with wrong command");

endmodule

`default_nettype wire
